// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Whenever the antecedent holds at a clock edge, the consequent holds too.
`define ASSERT_IMPLIES(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: implication violated");

// The condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_IMPLIES(name, clk, rst_n, pre, post)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// File: design/gda_pkg.sv
package gda_pkg;

    // Field widths of the stream payloads.
    localparam int unsigned AMT_W   = 14;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned OYEAR_W = 14;
    localparam int unsigned KIND_W  = 3;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned OUT_TUSER_W = 2;

    // Working year width: start year plus ten thousand decades fits in 17 bits.
    localparam int unsigned YEAR_W = 17;
    // Remaining-day counter: up to 9999 weeks of days.
    localparam int unsigned REM_W  = 17;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    // Year modulo 400 is found by restoring subtraction of 400 << k, k = 8 down to 0.
    localparam int unsigned MOD_BASE  = 400;
    localparam int unsigned MOD_STEPS = 9;
    localparam int unsigned K_W       = 4;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;
    localparam int unsigned      MONTHS_PER_YEAR = 12;
    localparam int unsigned      DAYS_PER_WEEK   = 7;
    localparam int unsigned      YEARS_PER_DECADE = 10;

    // Unit selector carried in the input tuser.
    typedef enum logic [KIND_W-1:0] {
        UNIT_DAYS    = 3'd0,
        UNIT_WEEKS   = 3'd1,
        UNIT_MONTHS  = 3'd2,
        UNIT_YEARS   = 3'd3,
        UNIT_DECADES = 3'd4
    } t_unit;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD_IN,
        S_CHECK,
        S_DAYS,
        S_MONTHS,
        S_SAT,
        S_MOD_OUT,
        S_CLAMP,
        S_PUB
    } t_state;

    // Datapath operation issued by the controller in each cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MOD,
        OP_CHECK,
        OP_DAY,
        OP_MONTH,
        OP_SAT,
        OP_CLAMP,
        OP_PUB
    } t_dp_op;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic              bad;
        logic [KIND_W-1:0] kind;
        logic              mod_last;
        logic              day_done;
        logic              month_done;
        logic              out_busy;
    } t_dp_status;

    // Leap rule from the low year bits and the year modulo 400.
    function automatic logic is_leap(input logic [1:0] y_lo, input logic [8:0] y_mod400);
        return (y_lo == 2'd0) && (y_mod400 != 9'd100) && (y_mod400 != 9'd200)
            && (y_mod400 != 9'd300);
    endfunction

    // Length of a month; months outside 1..12 are screened elsewhere.
    function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] m, input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MON_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

// File: design/gregorian_date_adder.sv
// Day and week units step one month per cycle, then finish inside the last month.
// Month units step one year per cycle, then add the leftover months.
// An invalid start date skips the calendar work.
// One transaction at a time: the next input is taken only after the result loads the output register.
// Synchronous active-low reset clears the controller and the output valid flag.
`include "assert_macros.svh"

module gregorian_date_adder #(
    parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // amount[13:0], start_day[18:14], start_month[22:19], start_year[36:23], zero[39:37]
    input  logic [gda_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // req_type[2:0]
    input  logic [gda_pkg::IN_TUSER_W-1:0]      i_s_tuser,
    // Output stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // end_day[4:0], end_month[8:5], end_year[22:9], zero[23]
    output logic [gda_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // bad_date[0], year_overflow[1]
    output logic [gda_pkg::OUT_TUSER_W-1:0]     o_m_tuser
);
    import gda_pkg::*;

    t_dp_op     op;
    t_dp_status status;

    // Sequencer.
    gda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_op       (op)
    );

    // Calendar datapath and output register.
    gda_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_status    (status),
        .i_in_data   (i_s_tdata),
        .i_in_user   (i_s_tuser),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .o_out_user  (o_m_tuser)
    );

    // An invalid start date never reports a year overflow.
    `ASSERT_NEVER(a_bad_no_ovf, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0] && o_m_tuser[1])

    // An overflowed result carries the saturated year.
    `ASSERT_IMPLIES(a_ovf_year, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1],
                    o_m_tdata[22:9] == OYEAR_W'(MAX_YEAR))

    // A result from a valid date has a real month and a nonzero day.
    `ASSERT_IMPLIES(a_date_range, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0],
                    (o_m_tdata[4:0] != 5'd0) && (o_m_tdata[8:5] >= MON_JAN)
                    && (o_m_tdata[8:5] <= MON_DEC))

    // The input is never taken while the controller is busy with a transaction.
    `ASSERT_IMPLIES(a_ready_idle, i_clk, i_rst_n, o_s_tready, op == OP_LOAD || op == OP_NONE)

endmodule

// File: design/gda_ctrl.sv
module gda_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  gda_pkg::t_dp_status i_status,
    output gda_pkg::t_dp_op     o_op
);
    import gda_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath operation.
    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_MOD_IN;
                end
            end
            S_MOD_IN: begin
                o_op = OP_MOD;
                if (i_status.mod_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_op = OP_CHECK;
                priority if (i_status.bad) begin
                    n_state = S_PUB;
                end else if (i_status.kind == UNIT_DAYS || i_status.kind == UNIT_WEEKS) begin
                    n_state = S_DAYS;
                end else if (i_status.kind == UNIT_MONTHS) begin
                    n_state = S_MONTHS;
                end else begin
                    n_state = S_SAT;
                end
            end
            S_DAYS: begin
                o_op = OP_DAY;
                if (i_status.day_done) begin
                    n_state = S_SAT;
                end
            end
            S_MONTHS: begin
                o_op = OP_MONTH;
                if (i_status.month_done) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                o_op    = OP_SAT;
                n_state = S_MOD_OUT;
            end
            S_MOD_OUT: begin
                o_op = OP_MOD;
                if (i_status.mod_last) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_op    = OP_CLAMP;
                n_state = S_PUB;
            end
            S_PUB: begin
                if (!i_status.out_busy) begin
                    o_op    = OP_PUB;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/gda_datapath.sv
module gda_datapath #(
    parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gda_pkg::t_dp_op                     i_op,
    output gda_pkg::t_dp_status                 o_status,
    input  logic [gda_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  logic [gda_pkg::IN_TUSER_W-1:0]      i_in_user,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [gda_pkg::OUT_TDATA_W-1:0]     o_out_data,
    output logic [gda_pkg::OUT_TUSER_W-1:0]     o_out_user
);
    import gda_pkg::*;

    localparam logic [YEAR_W-1:0] MaxYearW = YEAR_W'(MAX_YEAR);
    localparam logic [K_W-1:0]    KStart   = K_W'(MOD_STEPS - 1);

    // Working registers of the current transaction.
    logic [KIND_W-1:0] r_kind;
    logic [AMT_W-1:0]  r_amt;
    logic [DAY_W-1:0]  r_d;
    logic [MON_W-1:0]  r_m;
    logic [YEAR_W-1:0] r_y;
    logic [REM_W-1:0]  r_rem;
    logic [YEAR_W-1:0] r_mod;
    logic [K_W-1:0]    r_k;
    logic              r_bad;
    logic              r_ovf;

    // Output register.
    logic                r_out_valid;
    logic [DAY_W-1:0]    r_out_day;
    logic [MON_W-1:0]    r_out_mon;
    logic [OYEAR_W-1:0]  r_out_year;
    logic                r_out_bad;
    logic                r_out_ovf;

    logic              leap;
    logic [DAY_W-1:0]  dim;
    logic [DAY_W-1:0]  left;
    logic [YEAR_W-1:0] mod_sub;
    logic [YEAR_W-1:0] y_inc;
    logic [YEAR_W-1:0] mod_inc;
    logic [YEAR_W-1:0] y_sat;
    logic [DAY_W-1:0]  m_sum;
    logic              date_ok;
    logic [REM_W-1:0]  amt_week;
    logic [YEAR_W-1:0] amt_dec;

    // Calendar arithmetic on the current date.
    always_comb begin
        leap     = is_leap(r_y[1:0], r_mod[8:0]);
        dim      = days_in(r_m, leap);
        left     = dim - r_d;
        mod_sub  = YEAR_W'(MOD_BASE) << r_k;
        y_inc    = r_y + YEAR_W'(1);
        mod_inc  = (r_mod == YEAR_W'(MOD_BASE - 1)) ? '0 : r_mod + YEAR_W'(1);
        y_sat    = (r_y > MaxYearW) ? MaxYearW : r_y;
        m_sum    = {1'b0, r_m} + r_rem[DAY_W-1:0] - DAY_W'(1);
        date_ok  = (r_m >= MON_JAN) && (r_m <= MON_DEC) && (r_d != '0) && (r_d <= dim);
        amt_week = ({r_amt, 3'b000} - {3'b000, r_amt});
        amt_dec  = YEAR_W'({r_amt, 3'b000}) + YEAR_W'({r_amt, 1'b0});
    end

    // Status toward the controller.
    always_comb begin
        o_status.bad        = !date_ok;
        o_status.kind       = r_kind;
        o_status.mod_last   = (r_k == '0);
        o_status.day_done   = (r_rem <= REM_W'(left));
        o_status.month_done = (r_rem < REM_W'(MONTHS_PER_YEAR));
        o_status.out_busy   = r_out_valid && !i_out_ready;
    end

    // Working registers, one operation per cycle.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_kind <= i_in_user;
                r_amt  <= i_in_data[13:0];
                r_d    <= i_in_data[18:14];
                r_m    <= i_in_data[22:19];
                r_y    <= YEAR_W'(i_in_data[36:23]);
                r_mod  <= YEAR_W'(i_in_data[36:23]);
                r_k    <= KStart;
                r_bad  <= 1'b0;
                r_ovf  <= 1'b0;
            end
            OP_MOD: begin
                if (r_mod >= mod_sub) begin
                    r_mod <= r_mod - mod_sub;
                end
                if (r_k != '0) begin
                    r_k <= r_k - K_W'(1);
                end
            end
            OP_CHECK: begin
                r_bad <= !date_ok;
                if (date_ok) begin
                    if (r_kind == UNIT_DAYS || r_kind == UNIT_MONTHS) begin
                        r_rem <= REM_W'(r_amt);
                    end else if (r_kind == UNIT_WEEKS) begin
                        r_rem <= amt_week;
                    end else if (r_kind == UNIT_YEARS) begin
                        r_y <= r_y + YEAR_W'(r_amt);
                    end else if (r_kind == UNIT_DECADES) begin
                        r_y <= r_y + amt_dec;
                    end
                end
            end
            OP_DAY: begin
                // Finish inside this month, or move to the first of the next.
                if (r_rem <= REM_W'(left)) begin
                    r_d <= r_d + r_rem[DAY_W-1:0];
                end else begin
                    r_rem <= r_rem - REM_W'(left) - REM_W'(1);
                    r_d   <= DAY_W'(1);
                    if (r_m == MON_DEC) begin
                        r_m   <= MON_JAN;
                        r_y   <= y_inc;
                        r_mod <= mod_inc;
                    end else begin
                        r_m <= r_m + MON_W'(1);
                    end
                end
            end
            OP_MONTH: begin
                // Whole years first, then the leftover months.
                if (r_rem >= REM_W'(MONTHS_PER_YEAR)) begin
                    r_y   <= y_inc;
                    r_rem <= r_rem - REM_W'(MONTHS_PER_YEAR);
                end else if (m_sum >= DAY_W'(MONTHS_PER_YEAR)) begin
                    r_y <= y_inc;
                    r_m <= MON_W'(m_sum - DAY_W'(MONTHS_PER_YEAR - 1));
                end else begin
                    r_m <= MON_W'(m_sum + DAY_W'(1));
                end
            end
            OP_SAT: begin
                r_y   <= y_sat;
                r_ovf <= (r_y > MaxYearW);
                r_mod <= y_sat;
                r_k   <= KStart;
            end
            OP_CLAMP: begin
                if (r_d > dim) begin
                    r_d <= dim;
                end
            end
            OP_NONE, OP_PUB: begin
            end
            default: begin
            end
        endcase
    end

    // Output payload, loaded when the result is published.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_PUB) begin
            r_out_day  <= r_d;
            r_out_mon  <= r_m;
            r_out_year <= r_y[OYEAR_W-1:0];
            r_out_bad  <= r_bad;
            r_out_ovf  <= r_ovf;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_PUB) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {1'b0, r_out_year, r_out_mon, r_out_day};
    assign o_out_user  = {r_out_ovf, r_out_bad};

endmodule
